// File: hw/rtl/fpalu_pkg.sv
// shared types and constants for the fixed-point alu
package fpalu_pkg;

    // fraction bits at the default Q24.8 format
    localparam int FRAC_BITS_DEF = 8;
    // divide pre-shift of the dividend magnitude
    localparam int DIV_PRESHIFT  = 16;
    // one quotient bit per divider stage
    localparam int DIV_STEPS     = 32 + DIV_PRESHIFT;

    // action codes
    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_CMP = 3'd4;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               less;
        logic               equal;
        logic               greater;
        logic               div_by_zero;
    } rsp_t;

endpackage

// File: hw/rtl/fixed_point_alu.sv
// fixed-point alu top level: add, subtract, multiply, divide, compare
//
// Fully pipelined: a request is taken in every cycle (busy stays low) and its
// response appears with done after the stage 1 registers, the divider stages and
// the output register, for every action. The depth is set by the divider, which
// resolves one quotient bit per stage over 48 stages; the other actions ride
// alongside in a matching delay line so responses come out in request order.
// The receiver cannot stall, so done is a one-cycle strobe.
module fixed_point_alu #(
    parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  fpalu_pkg::req_t request,
    output logic            done,
    output fpalu_pkg::rsp_t response
);

    localparam int N      = fpalu_pkg::DIV_STEPS;
    localparam int RND_SH = fpalu_pkg::DIV_PRESHIFT - FRAC_BITS;
    localparam int SIDE   = N - 1;

    typedef struct packed {
        logic               valid;
        logic [2:0]         action;
        logic               neg;
        logic               dz;
        logic signed [31:0] res;
        logic               lt;
        logic               eq;
        logic               gt;
    } side_t;

    assign busy = 1'b0;

    // stage 1: operand magnitudes
    logic        s1_valid_reg;
    logic [2:0]  s1_action_reg;
    logic [31:0] s1_a_reg, s1_b_reg, s1_amag_reg, s1_bmag_reg;
    logic [31:0] amag_next, bmag_next;

    always_comb
    begin
        amag_next = request.operand_a[31] ? 32'(-request.operand_a) : request.operand_a;
        bmag_next = request.operand_b[31] ? 32'(-request.operand_b) : request.operand_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_action_reg <= request.action;
        s1_a_reg      <= request.operand_a;
        s1_b_reg      <= request.operand_b;
        s1_amag_reg   <= amag_next;
        s1_bmag_reg   <= bmag_next;
    end

    // divider runs from stage 1
    logic [N-1:0] quotient;

    fpalu_div u_div (
        .clk      (clk),
        .dividend ({s1_amag_reg, {fpalu_pkg::DIV_PRESHIFT{1'b0}}}),
        .divisor  (s1_bmag_reg),
        .quotient (quotient)
    );

    // stage 2: add, subtract, compare, the divide-by-zero flag and the raw product
    side_t       s2_next;
    side_t       s2_reg;
    logic [63:0] prod_reg;

    always_comb
    begin
        s2_next        = '0;
        s2_next.valid  = s1_valid_reg;
        s2_next.action = s1_action_reg;
        s2_next.neg    = s1_a_reg[31] ^ s1_b_reg[31];
        case (s1_action_reg)
            fpalu_pkg::ACT_ADD: s2_next.res = s1_a_reg + s1_b_reg;
            fpalu_pkg::ACT_SUB: s2_next.res = s1_a_reg - s1_b_reg;
            fpalu_pkg::ACT_DIV: s2_next.dz  = (s1_b_reg == 32'd0);
            fpalu_pkg::ACT_CMP:
            begin
                s2_next.lt = $signed(s1_a_reg) <  $signed(s1_b_reg);
                s2_next.eq = s1_a_reg == s1_b_reg;
                s2_next.gt = $signed(s1_a_reg) >  $signed(s1_b_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_reg <= '0;
        else
            s2_reg <= s2_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(s1_amag_reg) * 64'(s1_bmag_reg);
    end

    // delay line, multiply finished in its first stage
    side_t side_reg  [SIDE];
    side_t side_next [SIDE];

    always_comb
    begin
        logic [31:0] pmag;
        pmag = prod_reg[FRAC_BITS+31:FRAC_BITS];
        side_next[0] = s2_reg;
        if (s2_reg.action == fpalu_pkg::ACT_MUL)
            side_next[0].res = s2_reg.neg ? 32'(-pmag) : pmag;
        for (int k = 1; k < SIDE; k++)
            side_next[k] = side_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SIDE; k++)
                side_reg[k] <= '0;
        end
        else
        begin
            for (int k = 0; k < SIDE; k++)
                side_reg[k] <= side_next[k];
        end
    end

    // output stage: round and sign the quotient
    side_t       tail;
    logic [N:0]  rnd_sum;
    logic [31:0] qmag;
    logic        done_reg;
    fpalu_pkg::rsp_t rsp_reg, rsp_next;

    always_comb
    begin
        tail    = side_reg[SIDE-1];
        rnd_sum = {1'b0, quotient} + ((N+1)'(1) << (RND_SH - 1));
        qmag    = rnd_sum[RND_SH+31:RND_SH];
        rsp_next.result      = tail.res;
        rsp_next.less        = tail.lt;
        rsp_next.equal       = tail.eq;
        rsp_next.greater     = tail.gt;
        rsp_next.div_by_zero = tail.dz;
        if (tail.action == fpalu_pkg::ACT_DIV && !tail.dz)
            rsp_next.result = tail.neg ? 32'(-qmag) : qmag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= tail.valid;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done     = done_reg;
    assign response = rsp_reg;

    // every request gets its response after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(N + 2) done)
        else $error("response missing after request");

    // at most one compare flag
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $countones({response.less, response.equal, response.greater}) <= 1)
        else $error("more than one compare flag");

    // divide by zero and compare give a zero result
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (response.div_by_zero || response.less || response.equal
                 || response.greater) |-> response.result == 32'sd0)
        else $error("nonzero result with flag set");

endmodule

// File: hw/rtl/fpalu_div.sv
// pipelined restoring divider, one quotient bit per stage
module fpalu_div (
    input  logic                                 clk,
    input  logic [fpalu_pkg::DIV_STEPS-1:0]      dividend,
    input  logic [31:0]                          divisor,
    output logic [fpalu_pkg::DIV_STEPS-1:0]      quotient
);

    localparam int N = fpalu_pkg::DIV_STEPS;

    logic [31:0]  rem_reg [N];
    logic [N-1:0] nq_reg  [N];
    logic [31:0]  d_reg   [N];
    logic [31:0]  rem_next [N];
    logic [N-1:0] nq_next  [N];
    logic [31:0]  d_next   [N];

    // one trial subtract per stage
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            logic [31:0]  rem_in;
            logic [N-1:0] nq_in;
            logic [31:0]  d_in;
            logic [32:0]  shifted;
            logic [32:0]  diff;
            if (k == 0)
            begin
                rem_in = '0;
                nq_in  = dividend;
                d_in   = divisor;
            end
            else
            begin
                rem_in = rem_reg[k-1];
                nq_in  = nq_reg[k-1];
                d_in   = d_reg[k-1];
            end
            shifted = {rem_in, nq_in[N-1]};
            diff    = shifted - {1'b0, d_in};
            if (shifted >= {1'b0, d_in})
            begin
                rem_next[k] = diff[31:0];
                nq_next[k]  = {nq_in[N-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = shifted[31:0];
                nq_next[k]  = {nq_in[N-2:0], 1'b0};
            end
            d_next[k] = d_in;
        end
    end

    // stage registers, payload only
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            rem_reg[k] <= rem_next[k];
            nq_reg[k]  <= nq_next[k];
            d_reg[k]   <= d_next[k];
        end
    end

    assign quotient = nq_reg[N-1];

endmodule

// File: tb/alu_checker.sv
// checker for the fixed-point alu: predicts each response and compares in order
module alu_checker #(
    parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  fpalu_pkg::req_t request,
    input  logic            done,
    input  fpalu_pkg::rsp_t response,
    output int              errors,
    output int              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    fpalu_pkg::rsp_t expected_q[$];

    // magnitude of a raw operand, most negative value gives 2^31
    function automatic logic [63:0] mag_of(logic signed [31:0] v);
        logic [31:0] u;
        u = v[31] ? (~v + 32'd1) : v;
        return {32'd0, u};
    endfunction

    // expected response for one request
    function automatic fpalu_pkg::rsp_t alu_result(fpalu_pkg::req_t r);
        fpalu_pkg::rsp_t o;
        logic [63:0] prod;
        logic [63:0] quo;
        logic [31:0] m;
        logic neg;
        int sh;
        o = '0;
        neg = r.operand_a[31] ^ r.operand_b[31];
        sh = fpalu_pkg::DIV_PRESHIFT - FRAC_BITS;
        case (r.action)
            fpalu_pkg::ACT_ADD: o.result = r.operand_a + r.operand_b;
            fpalu_pkg::ACT_SUB: o.result = r.operand_a - r.operand_b;
            fpalu_pkg::ACT_MUL:
            begin
                prod = mag_of(r.operand_a) * mag_of(r.operand_b);
                m = 32'(prod >> FRAC_BITS);
                o.result = neg ? -m : m;
            end
            fpalu_pkg::ACT_DIV:
            begin
                if (r.operand_b == 0)
                begin
                    o.div_by_zero = 1'b1;
                end
                else
                begin
                    quo = (mag_of(r.operand_a) << fpalu_pkg::DIV_PRESHIFT)
                          / mag_of(r.operand_b);
                    quo = (quo + (64'd1 << (sh - 1))) >> sh;
                    m = quo[31:0];
                    o.result = neg ? -m : m;
                end
            end
            fpalu_pkg::ACT_CMP:
            begin
                o.less    = $signed(r.operand_a) < $signed(r.operand_b);
                o.equal   = r.operand_a == r.operand_b;
                o.greater = $signed(r.operand_a) > $signed(r.operand_b);
            end
            default: o = '0;
        endcase
        return o;
    endfunction

    task automatic report(string what, fpalu_pkg::rsp_t got, fpalu_pkg::rsp_t exp);
        $display("mismatch %s: got %h exp %h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    initial errors = 0;
    assign pending = expected_q.size();

    // accept requests and compare responses at the rising edge
    always @(posedge clk)
    begin
        fpalu_pkg::rsp_t exp;
        if (rst_n)
        begin
            if (start && !busy)
                expected_q.push_back(alu_result(request));
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    report("unexpected response", response, '0);
                end
                else
                begin
                    exp = expected_q.pop_front();
                    if (response.result !== exp.result)
                        report("result", response, exp);
                    if (response.less !== exp.less)
                        report("less", response, exp);
                    if (response.equal !== exp.equal)
                        report("equal", response, exp);
                    if (response.greater !== exp.greater)
                        report("greater", response, exp);
                    if (response.div_by_zero !== exp.div_by_zero)
                        report("div_by_zero", response, exp);
                end
            end
        end
    end
endmodule

// File: tb/tb_top.sv
// testbench top for the fixed-point alu: stimulus, timeout and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = fpalu_pkg::DIV_STEPS + 2;
    localparam int RANDOM_REQS = 900;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    fpalu_pkg::req_t request;
    logic done;
    fpalu_pkg::rsp_t response;
    int   errors;
    int   pending;
    int   cycles;
    int   sent;

    fixed_point_alu uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .request(request), .done(done), .response(response)
    );

    alu_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .response(response), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // operand with a bias toward edges and small values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 1024)) - 512);
            3: return 32'd0;
            4: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom();
        endcase
    endfunction

    // present one request and hold it until taken
    task automatic send(logic [2:0] act, logic [31:0] a, logic [31:0] b);
        start <= 1'b1;
        request <= '{action: act, operand_a: a, operand_b: b};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic idle(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [31:0] edges[4];
        int burst;
        cycles = 0;
        sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        edges = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff};
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every action on edge operands, divide by zero, unused codes
        for (int act = 0; act <= 4; act++)
            for (int k = 0; k < 4; k++)
                send(3'(act), edges[k], edges[(k + 1) % 4]);
        send(fpalu_pkg::ACT_DIV, 32'h0000_0100, 32'd0);
        send(fpalu_pkg::ACT_DIV, 32'h8000_0000, 32'h0000_0001);
        send(fpalu_pkg::ACT_CMP, 32'h1234_5678, 32'h1234_5678);
        send(3'd5, 32'h1, 32'h2);
        send(3'd6, 32'hffff_ffff, 32'h7fff_ffff);
        send(3'd7, 32'h8000_0000, 32'h8000_0000);

        // random bursts with random gaps
        while (sent < RANDOM_REQS + 26)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
                send($urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4)),
                     pick_operand(), pick_operand());
            case ($urandom_range(0, 3))
                0: idle(0);
                1: idle($urandom_range(1, 3));
                2: idle($urandom_range(4, 20));
                default:
                begin
                    // drain the pipeline completely before going on
                    start <= 1'b0;
                    do
                        @(negedge clk);
                    while (pending != 0);
                end
            endcase
        end
        start <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);

        $display("sent %0d requests: all five actions, unused codes, divide by zero,",
                 sent);
        $display("edge operands and random operands under bursty traffic");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
